>>> rtl/servo_pose_interpolation_sequencer_core_defines.svh
// Assertion macros used by the checker file of the servo pose sequencer.
// Depends on nothing; the using scope must provide clk and arst_n.
`ifndef SERVO_POSE_INTERPOLATION_SEQUENCER_CORE_DEFINES_SVH
`define SERVO_POSE_INTERPOLATION_SEQUENCER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPIS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("servo sequencer check failed");

// The consequent must hold in the cycle after the antecedent.
`define SPIS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("servo sequencer check failed");

`endif

>>> rtl/spis_pkg.sv
// Shared types, constants, codes and the pose angle table of the servo sequencer.
// Depends on nothing; the divider, datapath, controller and top level import it.
package spis_pkg;

	localparam int JOINTS = 4;
	localparam int POSES = 10;
	localparam int OUT_JOINTS = 4;
	localparam int JOINT_W = (JOINTS > 1) ? $clog2(JOINTS) : 1;
	localparam int PULSE_W = 12;
	localparam int ANGLE_W = 8;
	localparam int DIV_W = 20;

	localparam logic [4:0] POSE_CNT = 5'(POSES);
	localparam logic [ANGLE_W-1:0] ANGLE_MAX = 8'd180;
	localparam logic [15:0] DEFAULT_PERIOD = 16'd20;
	localparam logic [7:0] MIN_STEPS = 8'd2;
	localparam logic [PULSE_W-1:0] PULSE_MIN_RST = 12'd500;
	localparam logic [PULSE_W-1:0] PULSE_MAX_RST = 12'd2500;

	// Division by 180 is a shift by two and a multiply by ceil(2^24 / 45), which is
	// exact for every dividend below 2^20.
	localparam logic [18:0] PULSE_RECIP = 19'd372828;

	// Request opcodes.
	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_ABORT = 2'd2;
	localparam logic [1:0] OP_JUMP = 2'd3;

	// Configuration register indexes.
	localparam logic CFG_PULSE_MIN = 1'b0;
	localparam logic CFG_PULSE_MAX = 1'b1;

	// Datapath commands.
	localparam logic [2:0] DPOP_NOP = 3'd0;
	localparam logic [2:0] DPOP_LOAD = 3'd1;
	localparam logic [2:0] DPOP_MULA = 3'd2;
	localparam logic [2:0] DPOP_DIVA = 3'd3;
	localparam logic [2:0] DPOP_MULP = 3'd4;
	localparam logic [2:0] DPOP_DIVP = 3'd5;
	localparam logic [2:0] DPOP_WRITE = 3'd6;
	localparam logic [2:0] DPOP_CAPTURE = 3'd7;

	typedef logic [PULSE_W-1:0] pulse_t;
	typedef pulse_t [OUT_JOINTS-1:0] pulse_vec_t;

	typedef struct packed {
		logic [2:0] op;
		logic [3:0] src;
		logic [3:0] tgt;
		logic [7:0] k;
		logic [7:0] n;
	} spis_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic last_joint;
	} spis_sts_t;

	// Joint angles in degrees; rows past the built-in poses read as zero.
	localparam logic [ANGLE_W-1:0] POSE_ROM [0:15][0:7] = '{
		'{8'd90, 8'd70, 8'd110, 8'd90, 8'd0, 8'd0, 8'd0, 8'd0},
		'{8'd90, 8'd50, 8'd90, 8'd130, 8'd0, 8'd0, 8'd0, 8'd0},
		'{8'd90, 8'd35, 8'd70, 8'd60, 8'd0, 8'd0, 8'd0, 8'd0},
		'{8'd90, 8'd55, 8'd85, 8'd60, 8'd0, 8'd0, 8'd0, 8'd0},
		'{8'd50, 8'd50, 8'd90, 8'd130, 8'd0, 8'd0, 8'd0, 8'd0},
		'{8'd90, 8'd50, 8'd90, 8'd130, 8'd0, 8'd0, 8'd0, 8'd0},
		'{8'd130, 8'd50, 8'd90, 8'd130, 8'd0, 8'd0, 8'd0, 8'd0},
		'{8'd90, 8'd42, 8'd95, 8'd60, 8'd0, 8'd0, 8'd0, 8'd0},
		'{8'd90, 8'd52, 8'd82, 8'd60, 8'd0, 8'd0, 8'd0, 8'd0},
		'{8'd90, 8'd62, 8'd72, 8'd60, 8'd0, 8'd0, 8'd0, 8'd0},
		'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
		'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
		'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
		'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
		'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
		'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}
	};

endpackage

>>> rtl/spis_divider.sv
// Restoring unsigned divider, one quotient bit per cycle, 8-bit divisor.
// Depends on spis_pkg for the dividend width.
module spis_divider import spis_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [7:0]       divisor,
	output logic             busy,
	output logic [DIV_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] quo_q;
	logic [7:0]       rem_q;
	logic [7:0]       den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [8:0]       trial;
	logic             take;
	logic [7:0]       rem_next;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign take = (trial >= {1'b0, den_q});
	assign rem_next = take ? 8'(trial - {1'b0, den_q}) : trial[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CNT_W'(DIV_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], take};
			rem_q <= rem_next;
		end
	end

	assign busy = busy_q;
	assign quotient = quo_q;

endmodule

>>> rtl/spis_datapath.sv
// Datapath: pulse range registers, pose table, per-joint interpolation through a
// serial divider, pulse mapping by reciprocal multiplication, joint and result registers.
// Depends on spis_pkg and spis_divider.
module spis_datapath import spis_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wen,
	input  logic       cfg_index,
	input  logic [11:0] cfg_data,
	input  spis_cmd_t  cmd,
	output spis_sts_t  sts,
	output pulse_vec_t pulses
);

	logic [PULSE_W-1:0] pmin_q;
	logic [PULSE_W-1:0] pmax_q;
	pulse_t             joint_q [JOINTS];
	pulse_vec_t         res_q;
	pulse_vec_t         cur_vec;

	logic [3:0]         src_q;
	logic [3:0]         tgt_q;
	logic [7:0]         k_q;
	logic [7:0]         n_q;
	logic [JOINT_W-1:0] j_q;
	logic               neg_q;
	logic [DIV_W-1:0]   mag_q;
	logic [12:0]        pq_q;

	logic               div_start;
	logic               div_busy;
	logic [DIV_W-1:0]   quo;
	logic [36:0]        recip_prod;

	logic [ANGLE_W-1:0] a0;
	logic [ANGLE_W-1:0] a1;
	logic signed [8:0]  diff;
	logic signed [17:0] prod_a;
	logic [17:0]        mag_a;
	logic signed [21:0] quo_s;
	logic signed [21:0] ang_full;
	logic [ANGLE_W-1:0] ang;
	logic signed [12:0] span;
	logic signed [21:0] prod_p;
	logic [21:0]        mag_p;
	logic signed [14:0] q_s;
	logic signed [14:0] v;
	logic signed [14:0] lo_s;
	logic signed [14:0] hi_s;
	pulse_t             wv;

	assign a0 = POSE_ROM[src_q][3'(j_q)];
	assign a1 = POSE_ROM[tgt_q][3'(j_q)];

	// Angle step: (a1 - a0) * k, kept as sign and magnitude for the divider.
	always_comb begin
		diff = $signed({1'b0, a1}) - $signed({1'b0, a0});
		prod_a = diff * $signed({1'b0, k_q});
		mag_a = prod_a[17] ? 18'(-prod_a) : 18'(prod_a);
	end

	// Interpolated angle, clamped, then scaled by the pulse span.
	always_comb begin
		quo_s = $signed({2'b00, quo});
		ang_full = $signed({14'd0, a0}) + (neg_q ? -quo_s : quo_s);
		if (ang_full < 0) begin
			ang = '0;
		end else if (ang_full > $signed({14'd0, ANGLE_MAX})) begin
			ang = ANGLE_MAX;
		end else begin
			ang = ang_full[ANGLE_W-1:0];
		end
		span = $signed({1'b0, pmax_q}) - $signed({1'b0, pmin_q});
		prod_p = span * $signed({1'b0, ang});
		mag_p = prod_p[21] ? 22'(-prod_p) : 22'(prod_p);
	end

	assign recip_prod = mag_q[DIV_W-1:2] * PULSE_RECIP;

	// Final pulse: a value below pulse_min clamps to pulse_min before pulse_max is checked.
	always_comb begin
		q_s = $signed({2'b00, pq_q});
		lo_s = $signed({3'b000, pmin_q});
		hi_s = $signed({3'b000, pmax_q});
		v = lo_s + (neg_q ? -q_s : q_s);
		if (v < lo_s) begin
			wv = pmin_q;
		end else if (v > hi_s) begin
			wv = pmax_q;
		end else begin
			wv = v[PULSE_W-1:0];
		end
	end

	assign div_start = (cmd.op == DPOP_DIVA);

	spis_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag_q),
		.divisor  (n_q),
		.busy     (div_busy),
		.quotient (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pmin_q <= PULSE_MIN_RST;
			pmax_q <= PULSE_MAX_RST;
			for (int i = 0; i < JOINTS; i++) begin
				joint_q[i] <= '0;
			end
		end else begin
			if (cfg_wen) begin
				unique case (cfg_index)
					CFG_PULSE_MIN: pmin_q <= cfg_data;
					CFG_PULSE_MAX: pmax_q <= cfg_data;
				endcase
			end
			if (cmd.op == DPOP_WRITE) begin
				joint_q[j_q] <= wv;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			DPOP_NOP: begin
			end
			DPOP_LOAD: begin
				src_q <= cmd.src;
				tgt_q <= cmd.tgt;
				k_q <= cmd.k;
				n_q <= cmd.n;
				j_q <= '0;
			end
			DPOP_MULA: begin
				neg_q <= prod_a[17];
				mag_q <= DIV_W'(mag_a);
			end
			DPOP_DIVA: begin
			end
			DPOP_MULP: begin
				neg_q <= prod_p[21];
				mag_q <= DIV_W'(mag_p);
			end
			DPOP_DIVP: begin
				pq_q <= recip_prod[36:24];
			end
			DPOP_WRITE: begin
				j_q <= j_q + 1'b1;
			end
			DPOP_CAPTURE: begin
				res_q <= cur_vec;
			end
		endcase
	end

	for (genvar i = 0; i < OUT_JOINTS; i++) begin : g_out
		if (i < JOINTS) begin : g_on
			assign cur_vec[i] = joint_q[i];
		end else begin : g_off
			assign cur_vec[i] = '0;
		end
	end

	assign sts.div_busy = div_busy;
	assign sts.last_joint = (j_q == JOINT_W'(JOINTS - 1));
	assign pulses = res_q;

endmodule

>>> rtl/spis_ctrl.sv
// Controller: request decode, sequence state, step timing, the state machine
// that drives the datapath, and the result flag register.
// Depends on spis_pkg.
module spis_ctrl import spis_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic [1:0] op,
	input  logic [3:0] from_pose,
	input  logic [3:0] to_pose,
	input  logic [7:0] step_count,
	input  logic [15:0] step_period,
	output logic       res_valid,
	input  logic       res_stall,
	output logic       accepted,
	output logic       busy_res,
	output logic       moved,
	output spis_cmd_t  cmd,
	input  spis_sts_t  sts
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MULA = 4'd1;
	localparam logic [3:0] ST_DIVA = 4'd2;
	localparam logic [3:0] ST_WAITA = 4'd3;
	localparam logic [3:0] ST_MULP = 4'd4;
	localparam logic [3:0] ST_DIVP = 4'd5;
	localparam logic [3:0] ST_WAITP = 4'd6;
	localparam logic [3:0] ST_WRITE = 4'd7;
	localparam logic [3:0] ST_DONE = 4'd8;

	logic [3:0]  state_q;
	logic        running_q;
	logic [3:0]  src_q;
	logic [3:0]  tgt_q;
	logic [7:0]  total_q;
	logic [7:0]  cur_q;
	logic [15:0] period_q;
	logic [15:0] elapsed_q;
	logic        pend_acc_q;
	logic        pend_mov_q;
	logic        res_valid_q;
	logic        acc_out_q;
	logic        busy_out_q;
	logic        mov_out_q;

	logic        take_req;
	logic        out_free;
	logic        from_ok;
	logic        to_ok;
	logic [7:0]  steps_adj;
	logic [15:0] per_adj;
	logic [15:0] el_inc;
	logic        period_hit;
	logic        step_left;
	logic [7:0]  cur_next;
	logic        acc_now;
	logic        mov_now;
	logic [3:0]  sel_src;
	logic [3:0]  sel_tgt;
	logic [7:0]  sel_k;
	logic [7:0]  sel_n;

	assign req_stall = (state_q != ST_IDLE);
	assign take_req = req_valid && !req_stall;
	assign out_free = !res_valid_q || !res_stall;

	always_comb begin
		from_ok = ({1'b0, from_pose} < POSE_CNT);
		to_ok = ({1'b0, to_pose} < POSE_CNT);
		steps_adj = (step_count < MIN_STEPS) ? MIN_STEPS : step_count;
		per_adj = (step_period == '0) ? DEFAULT_PERIOD : step_period;
		el_inc = (elapsed_q != 16'hFFFF) ? elapsed_q + 16'd1 : elapsed_q;
		period_hit = (el_inc >= period_q);
		step_left = (cur_q < total_q);
		cur_next = cur_q + 8'd1;
		acc_now = 1'b0;
		mov_now = 1'b0;
		sel_src = src_q;
		sel_tgt = tgt_q;
		sel_k = cur_next;
		sel_n = total_q;
		unique case (op)
			OP_TICK: begin
				mov_now = running_q && period_hit && step_left;
			end
			OP_START: begin
				if (!running_q && from_ok && to_ok) begin
					acc_now = 1'b1;
					mov_now = 1'b1;
					sel_src = from_pose;
					sel_tgt = to_pose;
					sel_k = 8'd1;
					sel_n = steps_adj;
				end
			end
			OP_ABORT: begin
			end
			OP_JUMP: begin
				// A jump runs the step hardware with zero progress from the pose itself.
				if (to_ok) begin
					acc_now = 1'b1;
					mov_now = 1'b1;
					sel_src = to_pose;
					sel_tgt = to_pose;
					sel_k = 8'd0;
					sel_n = MIN_STEPS;
				end
			end
		endcase
	end

	always_comb begin
		cmd.src = sel_src;
		cmd.tgt = sel_tgt;
		cmd.k = sel_k;
		cmd.n = sel_n;
		case (state_q)
			ST_IDLE: cmd.op = take_req ? DPOP_LOAD : DPOP_NOP;
			ST_MULA: cmd.op = DPOP_MULA;
			ST_DIVA: cmd.op = DPOP_DIVA;
			ST_MULP: cmd.op = DPOP_MULP;
			ST_DIVP: cmd.op = DPOP_DIVP;
			ST_WRITE: cmd.op = DPOP_WRITE;
			ST_DONE: cmd.op = out_free ? DPOP_CAPTURE : DPOP_NOP;
			default: cmd.op = DPOP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			running_q <= 1'b0;
			src_q <= '0;
			tgt_q <= '0;
			total_q <= '0;
			cur_q <= '0;
			period_q <= '0;
			elapsed_q <= '0;
			pend_acc_q <= 1'b0;
			pend_mov_q <= 1'b0;
			res_valid_q <= 1'b0;
			acc_out_q <= 1'b0;
			busy_out_q <= 1'b0;
			mov_out_q <= 1'b0;
		end else begin
			// In the done state the output register is either held or reloaded below.
			if (res_valid_q && !res_stall && (state_q != ST_DONE)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (take_req) begin
						pend_acc_q <= acc_now;
						pend_mov_q <= mov_now;
						state_q <= mov_now ? ST_MULA : ST_DONE;
						unique case (op)
							OP_TICK: begin
								if (running_q) begin
									if (period_hit) begin
										elapsed_q <= '0;
										if (!step_left) begin
											running_q <= 1'b0;
										end else begin
											cur_q <= cur_next;
											if (cur_next >= total_q) begin
												running_q <= 1'b0;
											end
										end
									end else begin
										elapsed_q <= el_inc;
									end
								end
							end
							OP_START: begin
								if (acc_now) begin
									src_q <= from_pose;
									tgt_q <= to_pose;
									total_q <= steps_adj;
									period_q <= per_adj;
									elapsed_q <= '0;
									cur_q <= 8'd1;
									running_q <= 1'b1;
								end
							end
							OP_ABORT: begin
								running_q <= 1'b0;
							end
							OP_JUMP: begin
							end
						endcase
					end
				end
				ST_MULA: state_q <= ST_DIVA;
				ST_DIVA: state_q <= ST_WAITA;
				ST_WAITA: begin
					if (!sts.div_busy) begin
						state_q <= ST_MULP;
					end
				end
				ST_MULP: state_q <= ST_DIVP;
				ST_DIVP: state_q <= ST_WAITP;
				ST_WAITP: begin
					if (!sts.div_busy) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: state_q <= sts.last_joint ? ST_DONE : ST_MULA;
				ST_DONE: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						acc_out_q <= pend_acc_q;
						mov_out_q <= pend_mov_q;
						busy_out_q <= running_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign accepted = acc_out_q;
	assign busy_res = busy_out_q;
	assign moved = mov_out_q;

endmodule

>>> rtl/servo_pose_interpolation_sequencer_core.sv
// Four-joint servo pose sequencer. Each request beat is a one-millisecond tick,
// a sequence start, an abort or a direct pose jump, and each one yields exactly
// one result beat with the accepted, busy and moved flags and the four current
// pulse widths. A tick that applies no step, an abort or a refused request goes
// from idle straight to the done state, which loads the result into the output
// register once that is free and returns to idle for the next request. A beat
// that moves the joints first takes each joint through the angle multiply, the
// bit-serial divide of the interpolated angle and the wait on it, the multiply
// by the pulse span, the reciprocal scaling of the angle to a pulse width, a
// second wait and the write. The result sits in an output register, so the
// next request is taken while an earlier result still waits downstream.
// Depends on spis_pkg, spis_ctrl and spis_datapath.
module servo_pose_interpolation_sequencer_core import spis_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic        cfg_index,
	input  logic [11:0] cfg_data,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  op,
	input  logic [3:0]  from_pose,
	input  logic [3:0]  to_pose,
	input  logic [7:0]  step_count,
	input  logic [15:0] step_period,
	output logic        res_valid,
	input  logic        res_stall,
	output logic        accepted,
	output logic        busy_res,
	output logic        moved,
	output logic [11:0] pulse_base,
	output logic [11:0] pulse_shoulder,
	output logic [11:0] pulse_elbow,
	output logic [11:0] pulse_gripper
);

	spis_cmd_t  cmd;
	spis_sts_t  sts;
	pulse_vec_t pulses;

	spis_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.op          (op),
		.from_pose   (from_pose),
		.to_pose     (to_pose),
		.step_count  (step_count),
		.step_period (step_period),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.accepted    (accepted),
		.busy_res    (busy_res),
		.moved       (moved),
		.cmd         (cmd),
		.sts         (sts)
	);

	spis_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.pulses    (pulses)
	);

	assign pulse_base = pulses[0];
	assign pulse_shoulder = pulses[1];
	assign pulse_elbow = pulses[2];
	assign pulse_gripper = pulses[3];

endmodule

>>> rtl/spis_checker.sv
// Port-level checker for the servo pose sequencer and its bind to the top level.
// Depends on the assertion macros in servo_pose_interpolation_sequencer_core_defines.svh.
`include "servo_pose_interpolation_sequencer_core_defines.svh"

module spis_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_stall,
	input logic        res_valid,
	input logic        res_stall,
	input logic        accepted,
	input logic        busy_res,
	input logic        moved,
	input logic [11:0] pulse_base,
	input logic [11:0] pulse_shoulder,
	input logic [11:0] pulse_elbow,
	input logic [11:0] pulse_gripper
);

	// A stalled result stays offered and unchanged.
	`SPIS_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid)
	`SPIS_ASSERT_NEXT(a_res_stable, res_valid && res_stall, $stable(accepted) && $stable(moved) && $stable(busy_res) && $stable(pulse_base) && $stable(pulse_shoulder) && $stable(pulse_elbow) && $stable(pulse_gripper))

	// The block works on one request at a time.
	`SPIS_ASSERT_NEXT(a_one_in_flight, req_valid && !req_stall, req_stall)

	// Every accepted start or jump updates the pulses.
	`SPIS_ASSERT_SAME(a_accept_moves, res_valid && accepted, moved)

endmodule

bind servo_pose_interpolation_sequencer_core spis_checker u_spis_checker (.*);
